// ===== rtl/core/mhsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mhsc_pkg
// Shared widths, status codes and defaults for the max-heap swap counter.
// ----------------------------------------------------------------------------
`default_nettype none

package mhsc_pkg;

   localparam int VAL_W    = 31;
   localparam int SWAP_W   = 5;
   localparam int STATUS_W = 2;

   localparam int DEFAULT_CAPACITY = 65535;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/max_heap_swap_counter.sv =====
// ----------------------------------------------------------------------------
// max_heap_swap_counter
// Binary max-heap held in one synchronous RAM, reporting swaps per item.
//
//   channel   ports                                  handshake
//   request   req_mode, req_value                    start & !busy
//   response  rsp_swap_count, rsp_top_value,         rsp_valid, one cycle
//             rsp_status
//
// A push climbs from the new leaf; a pop loads the last entry and sifts it
// down from the root. Each level is a RAM read state and a compare-and-write
// state, but a push at the root or a pop at a leaf writes from the read
// state. All items end in the finish state, which registers the response
// strobe; refused items go there directly. An item makes at most 15 swaps
// at the default capacity. The occupancy count bounds every read whose data
// is used, so the RAM needs no clearing pass after reset. The receiver cannot
// stall; a new item may be started while the previous response is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_swap_counter
   import mhsc_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_mode,
   input  wire logic [VAL_W-1:0]    req_value,
   output logic                     rsp_valid,
   output logic [SWAP_W-1:0]        rsp_swap_count,
   output logic [VAL_W-1:0]         rsp_top_value,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int AW    = $clog2(CAPACITY + 1);
   localparam int DEPTH = CAPACITY + 1;
   localparam logic [AW-1:0] CAP_W = AW'(CAPACITY);
   localparam logic [AW-1:0] ROOT  = AW'(1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_UP_RD    = 3'd1;
   localparam logic [2:0] S_UP_CMP   = 3'd2;
   localparam logic [2:0] S_POP_LOAD = 3'd3;
   localparam logic [2:0] S_DN_RD    = 3'd4;
   localparam logic [2:0] S_DN_CMP   = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [SWAP_W-1:0]   swaps_ff, swaps_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0]    top_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SWAP_W-1:0]   rsp_swap_ff, rsp_swap_in;
   logic [VAL_W-1:0]    rsp_top_ff, rsp_top_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // heap RAM: one write port, two registered read ports
   logic [VAL_W-1:0]    heap_mem [DEPTH];
   logic [AW-1:0]       rd_addr_a, rd_addr_b, wr_addr;
   logic [VAL_W-1:0]    rd_data_a, rd_data_b, wr_data;
   logic                wr_en;

   logic [AW:0]         left_idx, right_idx;
   logic                left_ok, right_ok;

   assign left_idx  = {pos_ff, 1'b0};
   assign right_idx = {pos_ff, 1'b1};
   assign left_ok   = left_idx  <= {1'b0, count_ff};
   assign right_ok  = right_idx <= {1'b0, count_ff};

   always_ff @(posedge clock) begin
      rd_data_a <= heap_mem[rd_addr_a];
      rd_data_b <= heap_mem[rd_addr_b];
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      swaps_in      = swaps_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_swap_in   = rsp_swap_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr_a     = count_ff;
      rd_addr_b     = right_idx[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               swaps_in  = '0;
               status_in = STATUS_OK;
               if (req_mode == MODE_PUSH) begin
                  if (count_ff == CAP_W) begin
                     status_in = STATUS_PUSH_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     count_in = count_ff + ROOT;
                     pos_in   = count_ff + ROOT;
                     val_in   = req_value;
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_POP_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     // last entry is read this cycle and sifted down from the root
                     count_in = count_ff - ROOT;
                     state_in = S_POP_LOAD;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_addr_a = pos_ff >> 1;
            if (pos_ff == ROOT) begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (rd_data_a < val_ff) begin
               // parent moves down into the hole
               wr_en    = 1'b1;
               wr_data  = rd_data_a;
               pos_in   = pos_ff >> 1;
               swaps_in = swaps_ff + SWAP_W'(1);
               state_in = S_UP_RD;
            end else begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_POP_LOAD: begin
            val_in   = rd_data_a;
            pos_in   = ROOT;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
            if (!left_ok) begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            priority if (right_ok && rd_data_b > val_ff && rd_data_b >= rd_data_a) begin
               wr_en    = 1'b1;
               wr_data  = rd_data_b;
               pos_in   = right_idx[AW-1:0];
               swaps_in = swaps_ff + SWAP_W'(1);
               state_in = S_DN_RD;
            end else if (rd_data_a > val_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data_a;
               pos_in   = left_idx[AW-1:0];
               swaps_in = swaps_ff + SWAP_W'(1);
               state_in = S_DN_RD;
            end else begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_swap_in   = swaps_ff;
            rsp_status_in = status_ff;
            rsp_top_in    = (count_ff != '0) ? top_ff : '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      swaps_ff      <= swaps_in;
      status_ff     <= status_in;
      rsp_swap_ff   <= rsp_swap_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_status_ff <= rsp_status_in;
      // root mirror, so the top is known without a RAM read
      if (wr_en && wr_addr == ROOT) begin
         top_ff <= wr_data;
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_swap_count = rsp_swap_ff;
   assign rsp_top_value  = rsp_top_ff;
   assign rsp_status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_W)
      else $error("entry count above capacity");

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_FINISH))
      else $error("response without finish");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_refused_no_swaps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_swap_count == '0)
      else $error("refused item reports swaps");

   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_ff == '0 |-> rsp_top_value == '0)
      else $error("empty heap reports non-zero top");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_heap_swap_counter at its default capacity.
// A short directed sequence covers the empty-heap pop, extreme values, equal
// children on a pop and sifting to the root. Random items follow, with the
// heap growing and shrinking in bursts of pushes and pops. Each response is
// checked field by field against a behavioural heap, or a typed row's want.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import mhsc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEAP_CAP     = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int SETTLE_TICKS = 40;

   typedef struct packed {
      logic [SWAP_W-1:0]   swaps;
      logic [VAL_W-1:0]    top;
      logic [STATUS_W-1:0] status;
   } heap_result_type;

   typedef struct {
      logic               mode;
      logic [VAL_W-1:0]   value;
      bit                 typed;
      heap_result_type    want;
   } stim_row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                req_mode  = MODE_PUSH;
   logic [VAL_W-1:0]    req_value = '0;
   logic                busy;
   logic                rsp_valid;
   logic [SWAP_W-1:0]   rsp_swap_count;
   logic [VAL_W-1:0]    rsp_top_value;
   logic [STATUS_W-1:0] rsp_status;

   // behavioural heap
   logic [VAL_W-1:0] heap_mem [0:HEAP_CAP];
   int               heap_count;

   heap_result_type  expected_results [$];
   heap_result_type  rsp_want;
   stim_row_type     stim_rows [$];

   int idle_pct;
   int push_bias;
   int fail_count;
   int cycle_count;
   int n_push, n_pop, n_full, n_empty, max_swaps, max_fill;

   max_heap_swap_counter #(.CAPACITY(HEAP_CAP)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_swap_count (rsp_swap_count),
      .rsp_top_value  (rsp_top_value),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one item to the behavioural heap and returns its response.
   function automatic heap_result_type heap_apply(input logic mode,
                                                  input logic [VAL_W-1:0] value);
      heap_result_type  res;
      int               pos, nxt, lc, rc, swaps;
      logic [VAL_W-1:0] tmp, cur, lv, rv;
      bit               moving;
      res.status = STATUS_OK;
      swaps      = 0;
      if (mode == MODE_PUSH) begin
         if (heap_count >= HEAP_CAP) begin
            res.status = STATUS_PUSH_FULL;
         end else begin
            heap_count++;
            heap_mem[heap_count] = value;
            pos = heap_count;
            // strictly smaller parent only
            while (pos > 1 && heap_mem[pos / 2] < heap_mem[pos]) begin
               tmp                = heap_mem[pos / 2];
               heap_mem[pos / 2]  = heap_mem[pos];
               heap_mem[pos]      = tmp;
               pos                = pos / 2;
               swaps++;
            end
         end
      end else if (heap_count == 0) begin
         res.status = STATUS_POP_EMPTY;
      end else begin
         heap_mem[1]          = heap_mem[heap_count];
         heap_mem[heap_count] = '0;
         heap_count--;
         pos    = 1;
         moving = 1'b1;
         while (moving) begin
            lc  = 2 * pos;
            rc  = lc + 1;
            cur = heap_mem[pos];
            lv  = (lc <= heap_count) ? heap_mem[lc] : '0;
            rv  = (rc <= heap_count) ? heap_mem[rc] : '0;
            // equal children: right one wins
            if (rc <= heap_count && rv > cur && rv >= lv)
               nxt = rc;
            else if (lc <= heap_count && lv > cur)
               nxt = lc;
            else
               nxt = 0;
            if (nxt == 0) begin
               moving = 1'b0;
            end else begin
               tmp           = heap_mem[nxt];
               heap_mem[nxt] = heap_mem[pos];
               heap_mem[pos] = tmp;
               pos           = nxt;
               swaps++;
            end
         end
      end
      res.swaps = SWAP_W'(swaps);
      res.top   = (heap_count > 0) ? heap_mem[1] : '0;
      return res;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return {VAL_W{1'b1}};
         2, 3:    return VAL_W'($urandom_range(0, 15));
         default: return VAL_W'($urandom());
      endcase
   endfunction

   task automatic add_row(input logic mode, input logic [VAL_W-1:0] value,
                          input bit typed, input int swaps,
                          input logic [VAL_W-1:0] top,
                          input logic [STATUS_W-1:0] status);
      stim_row_type row;
      row.mode         = mode;
      row.value        = value;
      row.typed        = typed;
      row.want.swaps   = SWAP_W'(swaps);
      row.want.top     = top;
      row.want.status  = status;
      stim_rows.push_back(row);
   endtask

   // Presents one item, waits for it to be taken and records the response due.
   // start stays high on return so back-to-back items need no extra edge.
   task automatic send_item(input logic mode, input logic [VAL_W-1:0] value,
                            input bit typed, input heap_result_type want);
      heap_result_type res;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      res = heap_apply(mode, value);
      expected_results.push_back(typed ? want : res);
      if (mode == MODE_PUSH) n_push++; else n_pop++;
      if (res.status == STATUS_PUSH_FULL) n_full++;
      if (res.status == STATUS_POP_EMPTY) n_empty++;
      if (int'(res.swaps) > max_swaps) max_swaps = int'(res.swaps);
      if (heap_count > max_fill) max_fill = heap_count;
   endtask

   task automatic run_random(input int count, input int pct);
      logic mode;
      idle_pct = pct;
      repeat (count) begin
         // bursts of mostly pushes or mostly pops move the heap size around
         if ($urandom_range(0, 15) == 0) push_bias = $urandom_range(20, 80);
         mode = ($urandom_range(0, 99) < push_bias) ? MODE_PUSH : MODE_POP;
         send_item(mode, pick_value(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("response with no item outstanding: swaps %0d top %0h status %0d",
                   rsp_swap_count, rsp_top_value, rsp_status);
            fail_count++;
         end else begin
            rsp_want = expected_results.pop_front();
            if (rsp_swap_count !== rsp_want.swaps) begin
               $error("swap_count: expected %0d, got %0d", rsp_want.swaps, rsp_swap_count);
               fail_count++;
            end
            if (rsp_top_value !== rsp_want.top) begin
               $error("top_value: expected %0h, got %0h", rsp_want.top, rsp_top_value);
               fail_count++;
            end
            if (rsp_status !== rsp_want.status) begin
               $error("status: expected %0d, got %0d", rsp_want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("max_heap_swap_counter test failed");
         $finish;
      end
   end

   initial begin
      int k;
      fail_count  = 0;
      cycle_count = 0;
      n_push      = 0;
      n_pop       = 0;
      n_full      = 0;
      n_empty     = 0;
      max_swaps   = 0;
      max_fill    = 0;
      heap_count  = 0;
      push_bias   = 70;
      idle_pct    = 19;
      for (k = 0; k <= HEAP_CAP; k++) heap_mem[k] = '0;

      // empty heap, extremes, values ignored on pop
      add_row(MODE_POP,  '0,            1, 0, '0,            STATUS_POP_EMPTY);
      add_row(MODE_PUSH, '0,            1, 0, '0,            STATUS_OK);
      add_row(MODE_POP,  {VAL_W{1'b1}}, 1, 0, '0,            STATUS_OK);
      add_row(MODE_POP,  '0,            1, 0, '0,            STATUS_POP_EMPTY);
      add_row(MODE_PUSH, {VAL_W{1'b1}}, 1, 0, {VAL_W{1'b1}}, STATUS_OK);
      add_row(MODE_POP,  '0,            1, 0, '0,            STATUS_OK);
      // equal children on the pop that follows
      add_row(MODE_PUSH, 31'd9, 0, 0, '0, STATUS_OK);
      add_row(MODE_PUSH, 31'd7, 0, 0, '0, STATUS_OK);
      add_row(MODE_PUSH, 31'd7, 0, 0, '0, STATUS_OK);
      add_row(MODE_PUSH, 31'd1, 0, 0, '0, STATUS_OK);
      add_row(MODE_POP,  '0,    0, 0, '0, STATUS_OK);
      // alternating bits, sift to the root, equal to the root
      add_row(MODE_PUSH, 31'h5555_5555, 0, 0, '0, STATUS_OK);
      add_row(MODE_PUSH, 31'h2AAA_AAAA, 0, 0, '0, STATUS_OK);
      add_row(MODE_PUSH, {VAL_W{1'b1}}, 0, 0, '0, STATUS_OK);
      add_row(MODE_PUSH, {VAL_W{1'b1}}, 0, 0, '0, STATUS_OK);
      repeat (7) add_row(MODE_POP, pick_value(), 0, 0, '0, STATUS_OK);
      add_row(MODE_POP, '0, 1, 0, '0, STATUS_POP_EMPTY);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_item(stim_rows[i].mode, stim_rows[i].value, stim_rows[i].typed,
                   stim_rows[i].want);

      run_random(200, 19);
      run_random(200, 50);
      run_random(200, 0);

      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Covered %0d items: %0d pushes, %0d pops, %0d refused full, %0d refused empty",
               n_push + n_pop, n_push, n_pop, n_full, n_empty);
      $display("Heap reached %0d entries; largest swap count %0d", max_fill, max_swaps);
      if (fail_count == 0) begin
         $display("max_heap_swap_counter test passed");
      end else begin
         $display("max_heap_swap_counter test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
